// File: design/number_to_ascii_formatter_top_defines.svh
// Assertion macros used by the formatter's output serializer.
`ifndef NUMBER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define N2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define N2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/n2a_pkg.sv
// Types, constants and helper functions of the number to ASCII formatter.
package n2a_pkg;

  localparam int unsigned ValueWidth    = 16;
  localparam int unsigned DigitCount    = 5;
  localparam int unsigned BcdWidth      = 4 * DigitCount;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned BcdStages     = ValueWidth / StepsPerStage;
  localparam int unsigned MaxChars      = 8;
  localparam int unsigned IdxWidth      = $clog2(MaxChars);

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharOne    = 8'h31;
  localparam logic [7:0] CharLetter = 8'h41;
  localparam logic [7:0] HiNibMask  = 8'b1111_0000;
  localparam logic [7:0] LoNibMask  = 8'b0000_1111;

  localparam logic [IdxWidth-1:0] LastDecByte = IdxWidth'(2);
  localparam logic [IdxWidth-1:0] LastDecWord = IdxWidth'(4);
  localparam logic [IdxWidth-1:0] LastBinByte = IdxWidth'(7);
  localparam logic [IdxWidth-1:0] LastHexByte = IdxWidth'(1);

  typedef enum logic [1:0] {
    MODE_DEC_BYTE = 2'd0,
    MODE_DEC_WORD = 2'd1,
    MODE_BIN_BYTE = 2'd2,
    MODE_HEX_BYTE = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic [7:0]            low;
    logic [ValueWidth-1:0] shift;
    logic [BcdWidth-1:0]   bcd;
  } pipe_t;

  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [IdxWidth-1:0]      last_idx;
  } fmt_t;

  function automatic logic [BcdWidth-1:0] bcd_adjust(logic [BcdWidth-1:0] b);
    logic [BcdWidth-1:0] r;
    r = b;
    for (int d = 0; d < DigitCount; d++) begin
      if (r[4*d +: 4] >= 4'd5) begin
        r[4*d +: 4] = r[4*d +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] dec_char(logic [3:0] digit);
    return CharZero + {4'b0, digit};
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CharZero + {4'b0, nib};
    end else begin
      c = CharLetter + {4'b0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: design/number_to_ascii_formatter_top.sv
// Top level of the number to ASCII formatter.
//
// Input channel (valid_i/ready_o) takes a mode_i and value_i per beat; output
// channel (valid_o/ready_i) returns one ASCII character per beat, most
// significant first, with last_o on the final character of each value.
// Modes: decimal byte (3 chars), decimal word (5), binary byte (8), hex byte (2).
// Leading zeros are kept.
// Pipeline: four binary-to-BCD stages (four shift-add-3 steps each), one
// string build stage, then the serializer. The first character of a value is
// registered in each BCD stage, in the string build stage and in the serializer.
// Throughput: a value occupies the serializer for one output beat per character,
// one beat per cycle while ready_i is high; the stages in front buffer up to five values.
// When the receiver stalls, the current character holds and the stages fill
// up, then ready_o drops; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties every stage; ready_o is high
// right after reset.
module number_to_ascii_formatter_top
  import n2a_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] value_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);

  pipe_t bcd_data  [BcdStages+1];
  logic  bcd_valid [BcdStages+1];
  logic  bcd_ready [BcdStages+1];

  logic fmt_valid, ser_ready;
  fmt_t fmt_data;

  always_comb begin
    bcd_data[0].mode  = mode_e'(mode_i);
    bcd_data[0].low   = value_i[7:0];
    bcd_data[0].shift = (mode_e'(mode_i) == MODE_DEC_WORD) ? value_i : {8'h00, value_i[7:0]};
    bcd_data[0].bcd   = '0;
  end
  assign bcd_valid[0] = valid_i;
  assign ready_o      = bcd_ready[0];

  for (genvar g = 0; g < BcdStages; g++) begin : g_bcd
    n2a_bcd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (bcd_valid[g]),
      .ready_o (bcd_ready[g]),
      .data_i  (bcd_data[g]),
      .valid_o (bcd_valid[g+1]),
      .ready_i (bcd_ready[g+1]),
      .data_o  (bcd_data[g+1])
    );
  end

  n2a_fmt u_fmt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bcd_valid[BcdStages]),
    .ready_o (bcd_ready[BcdStages]),
    .data_i  (bcd_data[BcdStages]),
    .valid_o (fmt_valid),
    .ready_i (ser_ready),
    .data_o  (fmt_data)
  );

  n2a_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fmt_valid),
    .ready_o     (ser_ready),
    .data_i      (fmt_data),
    .valid_o     (valid_o),
    .ready_i     (ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// File: design/n2a_bcd_stage.sv
// One pipeline stage of the shift-add-3 binary to BCD conversion.
module n2a_bcd_stage
  import n2a_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  pipe_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output pipe_t data_o
);

  logic  valid_q;
  pipe_t data_d, data_q;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      data_d.bcd   = bcd_adjust(data_d.bcd);
      data_d.bcd   = {data_d.bcd[BcdWidth-2:0], data_d.shift[ValueWidth-1]};
      data_d.shift = {data_d.shift[ValueWidth-2:0], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/n2a_fmt.sv
// Pipeline stage that builds the character string of one value.
module n2a_fmt
  import n2a_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  pipe_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output fmt_t  data_o
);

  logic valid_q;
  fmt_t data_d, data_q;

  always_comb begin
    data_d.chars = '{default: CharZero};
    unique case (data_i.mode)
      MODE_DEC_BYTE: begin
        for (int k = 0; k < 3; k++) begin
          data_d.chars[k] = dec_char(data_i.bcd[4*(2-k) +: 4]);
        end
        data_d.last_idx = LastDecByte;
      end
      MODE_DEC_WORD: begin
        for (int k = 0; k < DigitCount; k++) begin
          data_d.chars[k] = dec_char(data_i.bcd[4*(DigitCount-1-k) +: 4]);
        end
        data_d.last_idx = LastDecWord;
      end
      MODE_BIN_BYTE: begin
        for (int k = 0; k < 8; k++) begin
          data_d.chars[k] = data_i.low[7-k] ? CharOne : CharZero;
        end
        data_d.last_idx = LastBinByte;
      end
      MODE_HEX_BYTE: begin
        data_d.chars[0] = hex_char(4'((data_i.low & HiNibMask) >> 4));
        data_d.chars[1] = hex_char(4'(data_i.low & LoNibMask));
        data_d.last_idx = LastHexByte;
      end
      default: begin
        data_d.last_idx = LastHexByte;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/n2a_ser.sv
// Output serializer: sends one character beat per cycle from a held string while ready_i is high.
`include "number_to_ascii_formatter_top_defines.svh"

module n2a_ser
  import n2a_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  fmt_t       data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] character_o,
  output logic       last_o
);

  logic                valid_q;
  logic [IdxWidth-1:0] idx_d, idx_q;
  fmt_t                data_q;
  logic                is_last;
  logic                out_fire;

  assign is_last  = (idx_q == data_q.last_idx);
  assign out_fire = valid_q && ready_i;
  assign ready_o  = !valid_q || (out_fire && is_last);

  always_comb begin
    idx_d = idx_q;
    if (ready_o) begin
      idx_d = '0;
    end else if (out_fire) begin
      idx_d = idx_q + IdxWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o     = valid_q;
  assign character_o = data_q.chars[idx_q];
  assign last_o      = is_last;

  `N2A_ASSERT_NOW(a_idx_in_range, valid_q, idx_q <= data_q.last_idx, "char index past end")
  `N2A_ASSERT_NOW(a_len_legal, valid_q,
    data_q.last_idx == LastDecByte || data_q.last_idx == LastDecWord ||
    data_q.last_idx == LastBinByte || data_q.last_idx == LastHexByte, "bad string length")
  `N2A_ASSERT_NEXT(a_idx_step, out_fire && !is_last,
    valid_q && idx_q == $past(idx_q) + IdxWidth'(1), "char index did not advance")
  `N2A_ASSERT_NEXT(a_stall_hold, valid_q && !ready_i,
    valid_q && $stable(idx_q), "stalled beat changed")

endmodule

// File: bench/number_to_ascii_formatter_top_test.sv
// Testbench for the number to ASCII formatter: queued stimulus, per-character text prediction.
`timescale 1ns / 1ps

module number_to_ascii_formatter_top_test;
  import n2a_pkg::*;

  localparam int unsigned QuietItems = 60;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] value;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [1:0]  mode_i = 2'b00;
  logic [15:0] value_i = 16'h0000;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [7:0]  character_o;
  logic        last_o;

  fmt_req_t   req_q[$];
  char_beat_t text_q[$];

  bit          in_fire = 1'b0;
  bit          hold_rx = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned reqs_taken = 0;
  int unsigned mismatches = 0;

  number_to_ascii_formatter_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .ready_o    (ready_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .valid_o    (valid_o),
    .ready_i    (ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void push_char(logic [7:0] c);
    text_q.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic logic [7:0] hex_ascii(logic [3:0] nib);
    if (nib < 4'd10) begin
      return CharZero + {4'b0, nib};
    end
    return CharLetter + {4'b0, nib - 4'd10};
  endfunction

  // Expected characters of one value, most significant first.
  function automatic void predict_text(mode_e m, logic [15:0] v);
    logic [7:0]  lo;
    int unsigned w;
    char_beat_t  b;
    lo = v[7:0];
    w  = v;
    case (m)
      MODE_DEC_BYTE: begin
        push_char(CharZero + 8'(lo / 100));
        push_char(CharZero + 8'((lo / 10) % 10));
        push_char(CharZero + 8'(lo % 10));
      end
      MODE_DEC_WORD: begin
        push_char(CharZero + 8'(w / 10000));
        push_char(CharZero + 8'((w / 1000) % 10));
        push_char(CharZero + 8'((w / 100) % 10));
        push_char(CharZero + 8'((w / 10) % 10));
        push_char(CharZero + 8'(w % 10));
      end
      MODE_BIN_BYTE: begin
        for (int i = 7; i >= 0; i--) begin
          push_char(lo[i] ? CharOne : CharZero);
        end
      end
      default: begin
        push_char(hex_ascii(lo[7:4]));
        push_char(hex_ascii(lo[3:0]));
      end
    endcase
    b = text_q.pop_back();
    b.last = 1'b1;
    text_q.push_back(b);
  endfunction

  function automatic void add_req(mode_e m, logic [15:0] v);
    req_q.push_back('{mode: m, value: v});
  endfunction

  // Drives the input channel and the receiver's ready.
  always @(negedge clk_i) begin
    bit       quiet;
    fmt_req_t r;
    if (rst_ni) begin
      quiet = req_q.size() < QuietItems;
      if (!valid_i || in_fire) begin
        if (send_gap > 0) begin
          valid_i  <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (req_q.size() > 0) begin
          r = req_q.pop_front();
          valid_i <= 1'b1;
          mode_i  <= r.mode;
          value_i <= r.value;
          if (!quiet && !hold_rx && $urandom_range(0, 3) == 0) begin
            send_gap <= $urandom_range(1, 12);
          end
        end else begin
          valid_i <= 1'b0;
        end
      end
      if (hold_rx) begin
        ready_i <= 1'b0;
      end else if (quiet) begin
        ready_i <= 1'b1;
      end else if (recv_gap > 0) begin
        ready_i  <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        ready_i  <= 1'b0;
        recv_gap <= $urandom_range(0, 11);
      end else begin
        ready_i <= 1'b1;
      end
    end
  end

  // Samples both channels; predicts on input beats, checks output beats.
  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni) begin
      in_fire = valid_i && ready_o;
      if (in_fire) begin
        predict_text(mode_e'(mode_i), value_i);
        reqs_taken++;
      end
      if (valid_o && ready_i) begin
        if (text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected char beat: char=%h last=%b", character_o, last_o);
          end
        end else begin
          want = text_q.pop_front();
          if (character_o !== want.ch || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("char beat mismatch: exp char=%h last=%b, got char=%h last=%b",
                       want.ch, want.last, character_o, last_o);
            end
          end
        end
      end
    end
  end

  // Long receiver stall while the sender keeps offering.
  initial begin
    while (reqs_taken < 120) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned sel;
    logic [15:0] v;
    // directed: extremes, every mode, high byte ignored, hex letters
    add_req(MODE_DEC_BYTE, 16'h0000);
    add_req(MODE_DEC_BYTE, 16'h00FF);
    add_req(MODE_DEC_BYTE, 16'hFF00);
    add_req(MODE_DEC_BYTE, 16'hAB64);
    add_req(MODE_DEC_WORD, 16'h0000);
    add_req(MODE_DEC_WORD, 16'hFFFF);
    add_req(MODE_DEC_WORD, 16'd9999);
    add_req(MODE_DEC_WORD, 16'd10000);
    add_req(MODE_DEC_WORD, 16'd59999);
    add_req(MODE_DEC_WORD, 16'd60000);
    add_req(MODE_BIN_BYTE, 16'h0000);
    add_req(MODE_BIN_BYTE, 16'hFFFF);
    add_req(MODE_BIN_BYTE, 16'h55AA);
    add_req(MODE_BIN_BYTE, 16'hFF01);
    add_req(MODE_HEX_BYTE, 16'h0000);
    add_req(MODE_HEX_BYTE, 16'h00FF);
    add_req(MODE_HEX_BYTE, 16'hFF09);
    add_req(MODE_HEX_BYTE, 16'h00AF);
    add_req(MODE_HEX_BYTE, 16'h12BC);
    add_req(MODE_HEX_BYTE, 16'h34DE);
    add_req(MODE_HEX_BYTE, 16'h00A0);
    add_req(MODE_DEC_BYTE, 16'h0063);
    add_req(MODE_DEC_BYTE, 16'h0064);
    for (int i = 0; i < 460; i++) begin
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        v = 16'($urandom);
      end else if (sel == 6) begin
        v = 16'($urandom_range(0, 255));
      end else if (sel == 7) begin
        v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else if (sel == 8) begin
        v = {8'($urandom), ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      end else begin
        v = 16'h0001 << $urandom_range(0, 15);
      end
      add_req(mode_e'($urandom_range(0, 3)), v);
    end

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() > 0 || valid_i) @(posedge clk_i);
    while (text_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (mismatches == 0 && text_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
